// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pcm_pkg.sv =====
// ----------------------------------------------------------------------------
// pcm_pkg
// Constants, request codes and byte scaling shared by the page commitment map.
// ----------------------------------------------------------------------------
package pcm_pkg;

	// map geometry
	localparam int PAGES     = 64;
	localparam int PG_W      = $clog2(PAGES);
	localparam int CNT_W     = $clog2(PAGES + 1);
	localparam int MAX_RUNS  = 32;
	localparam int RUN_CNT_W = $clog2(MAX_RUNS + 1);

	// field widths
	localparam int FUNC_W    = 2;
	localparam int ADDR_W    = 32;
	localparam int SHIFT_W   = 5;
	localparam int SHIFT_MAX = 16;
	localparam int BYTES_W   = 23;
	localparam int RUN_OFF_W = 22;

	// request codes
	localparam logic [FUNC_W-1:0] FUNC_COMMIT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DECOMMIT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SCAN     = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd3;

	// page count times page size, truncated to the byte field width
	function automatic logic [BYTES_W-1:0] pages_to_bytes(
		input logic [CNT_W-1:0]   pages,
		input logic [SHIFT_W-1:0] sh
	);
		logic [BYTES_W+CNT_W-1:0] wide;
		wide = {{BYTES_W{1'b0}}, pages} << sh;
		return wide[BYTES_W-1:0];
	endfunction

endpackage

// ===== rtl/page_commitment_map.sv =====
// Range updates (commit, decommit) pass decode, bounds check, a walk of the map
// and a response; a scan walks the map and flushes its final run at the end;
// clear, misaligned and empty requests go to the response after decode, and
// out-of-range ones after the bounds check. A new request is taken only in idle.
// Reset clears the commit map, the page count and the output valid flag; page_shift is 16.
// ----------------------------------------------------------------------------
// page_commitment_map
// Commit bitmap over the pages of a sparse buffer with committed-run scan.
// A rotating map register is walked by a sequencer at one page per cycle but for
// scan output stalls; it updates ranges, counts committed pages, reports committed runs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module page_commitment_map (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [pcm_pkg::SHIFT_W-1:0]        cfg_data,
	// request channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [pcm_pkg::FUNC_W-1:0]         func,
	input  logic [pcm_pkg::ADDR_W-1:0]         offset_bytes,
	input  logic [pcm_pkg::ADDR_W-1:0]         size_bytes,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               changed,
	output logic                               error,
	output logic [pcm_pkg::BYTES_W-1:0]        committed_bytes,
	output logic                               run_valid,
	output logic [pcm_pkg::RUN_OFF_W-1:0]      run_offset,
	output logic [pcm_pkg::BYTES_W-1:0]        run_size,
	output logic                               last
);
	import pcm_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_BOUND  = 3'd2;
	localparam logic [2:0] S_UPDATE = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_FLUSH  = 3'd5;
	localparam logic [2:0] S_RESP   = 3'd6;

	logic [2:0]           state_q;
	logic [SHIFT_W-1:0]   page_shift_q;
	logic [SHIFT_W-1:0]   sh;

	// latched request
	logic [FUNC_W-1:0]    func_q;
	logic [ADDR_W-1:0]    off_q;
	logic [ADDR_W-1:0]    size_q;
	logic [ADDR_W-1:0]    start_q;
	logic [ADDR_W-1:0]    npg_q;
	logic [CNT_W-1:0]     rs_q;
	logic [CNT_W-1:0]     re_q;

	// map and walk state
	logic [PAGES-1:0]     map_q;
	logic [CNT_W-1:0]     count_q;
	logic [PG_W-1:0]      pos_q;
	logic                 chg_q;
	logic                 err_q;
	logic                 in_run_q;
	logic [PG_W-1:0]      run_start_q;
	logic                 pend_v_q;
	logic [PG_W-1:0]      pend_start_q;
	logic [CNT_W-1:0]     pend_len_q;
	logic [RUN_CNT_W-1:0] runs_q;
	logic                 capped_q;

	// output register
	logic                 out_valid_q;
	logic                 changed_q;
	logic                 error_q;
	logic [BYTES_W-1:0]   bytes_q;
	logic                 run_valid_q;
	logic [RUN_OFF_W-1:0] run_off_q;
	logic [BYTES_W-1:0]   run_size_q;
	logic                 last_q;

	// combinational helpers
	logic                 out_free;
	logic                 at_end;
	logic                 cur;
	logic [CNT_W-1:0]     pos_ext;
	logic [ADDR_W-1:0]    mask;
	logic                 misaligned;
	logic [ADDR_W:0]      end_w;
	logic                 in_rng;
	logic                 want;
	logic                 nb;
	logic                 end_mid;
	logic                 found;
	logic [PG_W-1:0]      new_start;
	logic [CNT_W-1:0]     new_end;
	logic [CNT_W-1:0]     new_len;
	logic                 scan_stall;
	logic                 rotate;

	// output load selection
	logic                 ld_out;
	logic                 ld_chg;
	logic                 ld_err;
	logic                 ld_rv;
	logic [PG_W-1:0]      ld_start;
	logic [CNT_W-1:0]     ld_len;
	logic                 ld_last;
	logic [BYTES_W-1:0]   ld_off_wide;

	// page shift saturates at 64 KiB pages
	assign sh = (page_shift_q > SHIFT_W'(SHIFT_MAX)) ? SHIFT_W'(SHIFT_MAX) : page_shift_q;

	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == S_IDLE);
	assign at_end     = (pos_q == PG_W'(PAGES - 1));
	assign cur        = map_q[0];
	assign pos_ext    = CNT_W'(pos_q);
	assign mask       = ~({ADDR_W{1'b1}} << sh);
	assign misaligned = (|(off_q & mask)) || (|(size_q & mask));
	assign end_w      = {1'b0, start_q} + {1'b0, npg_q};

	// range update of the current page
	assign in_rng = (pos_ext >= rs_q) && (pos_ext < re_q);
	assign want   = (func_q == FUNC_COMMIT);
	assign nb     = in_rng ? want : cur;

	// run detection at the current page
	assign end_mid    = in_run_q && !cur;
	assign found      = !capped_q && (end_mid || (at_end && cur));
	assign new_start  = in_run_q ? run_start_q : pos_q;
	assign new_end    = end_mid ? pos_ext : CNT_W'(PAGES);
	assign new_len    = new_end - CNT_W'(new_start);
	assign scan_stall = found && pend_v_q && !out_free;
	assign rotate     = (state_q == S_UPDATE) || ((state_q == S_SCAN) && !scan_stall);

	// result to load into the output register
	always_comb begin
		ld_out   = 1'b0;
		ld_chg   = 1'b0;
		ld_err   = 1'b0;
		ld_rv    = 1'b0;
		ld_start = '0;
		ld_len   = '0;
		ld_last  = 1'b1;
		case (state_q)
			S_RESP: begin
				ld_out = out_free;
				ld_chg = chg_q;
				ld_err = err_q;
			end
			S_SCAN: begin
				if (found && pend_v_q && out_free) begin
					ld_out   = 1'b1;
					ld_rv    = 1'b1;
					ld_start = pend_start_q;
					ld_len   = pend_len_q;
					ld_last  = 1'b0;
				end
			end
			S_FLUSH: begin
				ld_out = out_free;
				if (pend_v_q) begin
					ld_rv    = 1'b1;
					ld_start = pend_start_q;
					ld_len   = pend_len_q;
				end
			end
			default: begin
				ld_out = 1'b0;
			end
		endcase
	end

	assign ld_off_wide = pages_to_bytes(CNT_W'(ld_start), sh);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_shift_q <= SHIFT_W'(SHIFT_MAX);
		end else if (cfg_we) begin
			page_shift_q <= cfg_data;
		end
	end

	// request payload and decode results
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q <= func;
			off_q  <= offset_bytes;
			size_q <= size_bytes;
		end
		if (state_q == S_DECODE) begin
			start_q <= off_q >> sh;
			npg_q   <= size_q >> sh;
		end
		if (state_q == S_BOUND) begin
			rs_q <= CNT_W'(start_q);
			re_q <= CNT_W'(end_w);
		end
	end

	// sequencer, map walk and run tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			map_q        <= '0;
			count_q      <= '0;
			pos_q        <= '0;
			chg_q        <= 1'b0;
			err_q        <= 1'b0;
			in_run_q     <= 1'b0;
			run_start_q  <= '0;
			pend_v_q     <= 1'b0;
			pend_start_q <= '0;
			pend_len_q   <= '0;
			runs_q       <= '0;
			capped_q     <= 1'b0;
		end else begin
			// one page per cycle unless a scan stalls, map returns to its place after a full walk
			if (rotate) begin
				map_q <= {(state_q == S_UPDATE) ? nb : cur, map_q[PAGES-1:1]};
				pos_q <= pos_q + PG_W'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (func_q == FUNC_SCAN) begin
						chg_q    <= 1'b0;
						err_q    <= 1'b0;
						in_run_q <= 1'b0;
						pend_v_q <= 1'b0;
						runs_q   <= '0;
						capped_q <= 1'b0;
						state_q  <= S_SCAN;
					end else if (func_q == FUNC_CLEAR) begin
						chg_q   <= (count_q != '0);
						err_q   <= 1'b0;
						map_q   <= '0;
						count_q <= '0;
						state_q <= S_RESP;
					end else if (misaligned) begin
						chg_q   <= 1'b0;
						err_q   <= 1'b1;
						state_q <= S_RESP;
					end else if (size_q == '0) begin
						chg_q   <= 1'b0;
						err_q   <= 1'b0;
						state_q <= S_RESP;
					end else begin
						chg_q   <= 1'b0;
						err_q   <= 1'b0;
						state_q <= S_BOUND;
					end
				end
				S_BOUND: begin
					if (end_w > (ADDR_W + 1)'(PAGES)) begin
						err_q   <= 1'b1;
						state_q <= S_RESP;
					end else begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (in_rng && (cur != want)) begin
						chg_q <= 1'b1;
						if (want) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							count_q <= count_q - CNT_W'(1);
						end
					end
					if (at_end) begin
						state_q <= S_RESP;
					end
				end
				S_SCAN: begin
					if (!scan_stall) begin
						if (cur && !in_run_q) begin
							run_start_q <= pos_q;
						end
						in_run_q <= cur;
						if (found) begin
							pend_v_q     <= 1'b1;
							pend_start_q <= new_start;
							pend_len_q   <= new_len;
							runs_q       <= runs_q + RUN_CNT_W'(1);
							if (runs_q == RUN_CNT_W'(MAX_RUNS - 1)) begin
								capped_q <= 1'b1;
							end
						end
						if (at_end) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (ld_out) begin
			changed_q   <= ld_chg;
			error_q     <= ld_err;
			bytes_q     <= pages_to_bytes(count_q, sh);
			run_valid_q <= ld_rv;
			run_off_q   <= ld_off_wide[RUN_OFF_W-1:0];
			run_size_q  <= pages_to_bytes(ld_len, sh);
			last_q      <= ld_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign changed         = changed_q;
	assign error           = error_q;
	assign committed_bytes = bytes_q;
	assign run_valid       = run_valid_q;
	assign run_offset      = run_off_q;
	assign run_size        = run_size_q;
	assign last            = last_q;

	// checks on the walk and the result encoding
	`ASSERT_IMPLIES(a_count_matches_map, state_q == S_IDLE, count_q == CNT_W'($countones(map_q)), "page count differs from map")
	`ASSERT_IMPLIES(a_walk_rewound, state_q == S_IDLE, pos_q == '0, "map walk not back at page zero")
	`ASSERT_IMPLIES(a_run_no_flags, out_valid_q && run_valid_q, !changed_q && !error_q, "run item carries change or error")
	`ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(PAGES), "page count above map size")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page commitment map. Requests go in one item at
// a time over valid/ready. A shadow commit map predicts every result item:
// range updates, clears and committed-run scans. A response process checks
// each result against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
	import pcm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 70;

	typedef struct packed {
		logic                 changed;
		logic                 error;
		logic [BYTES_W-1:0]   committed_bytes;
		logic                 run_valid;
		logic [RUN_OFF_W-1:0] run_offset;
		logic [BYTES_W-1:0]   run_size;
		logic                 last;
	} map_response_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [SHIFT_W-1:0]   cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [FUNC_W-1:0]    func;
	logic [ADDR_W-1:0]    offset_bytes;
	logic [ADDR_W-1:0]    size_bytes;
	logic                 out_valid;
	logic                 out_ready;
	logic                 changed;
	logic                 error;
	logic [BYTES_W-1:0]   committed_bytes;
	logic                 run_valid;
	logic [RUN_OFF_W-1:0] run_offset;
	logic [BYTES_W-1:0]   run_size;
	logic                 last;

	// shadow state of the block
	logic [PAGES-1:0]     commit_bits;
	int                   page_cnt;
	logic [SHIFT_W-1:0]   page_shift;

	map_response_t        map_responses[$];
	int                   fail_count;
	int                   cycle_count;
	bit                   no_idle;

	page_commitment_map DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.offset_bytes    (offset_bytes),
		.size_bytes      (size_bytes),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.changed         (changed),
		.error           (error),
		.committed_bytes (committed_bytes),
		.run_valid       (run_valid),
		.run_offset      (run_offset),
		.run_size        (run_size),
		.last            (last)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// effective page shift, saturated at the largest page
	function automatic int page_bits();
		return (page_shift > SHIFT_MAX) ? SHIFT_MAX : int'(page_shift);
	endfunction

	// committed page count scaled to bytes
	function automatic logic [BYTES_W-1:0] count_bytes(int cnt, int sh);
		return BYTES_W'(64'(cnt) << sh);
	endfunction

	// apply one request to the shadow map and queue the result items it causes
	task automatic update_commit_map(input logic [FUNC_W-1:0] f,
			input logic [ADDR_W-1:0] off, input logic [ADDR_W-1:0] size);
		int            sh;
		int            pos;
		int            runs;
		int            i;
		int            run_start[MAX_RUNS];
		int            run_len[MAX_RUNS];
		logic [63:0]   mask;
		logic [63:0]   first;
		logic [63:0]   stop;
		logic          want;
		map_response_t rsp;
		sh   = page_bits();
		mask = (64'd1 << sh) - 64'd1;
		rsp  = '0;
		rsp.last = 1'b1;
		if (f == FUNC_SCAN) begin
			// collect maximal runs of committed pages from page 0 up
			runs = 0;
			pos  = 0;
			while (pos < PAGES && runs < MAX_RUNS) begin
				while (pos < PAGES && !commit_bits[pos])
					pos++;
				if (pos < PAGES) begin
					run_start[runs] = pos;
					while (pos < PAGES && commit_bits[pos])
						pos++;
					run_len[runs] = pos - run_start[runs];
					runs++;
				end
			end
			rsp.committed_bytes = count_bytes(page_cnt, sh);
			if (runs == 0) begin
				map_responses.push_back(rsp);
			end else begin
				for (i = 0; i < runs; i++) begin
					rsp.run_valid  = 1'b1;
					rsp.run_offset = RUN_OFF_W'(64'(run_start[i]) << sh);
					rsp.run_size   = BYTES_W'(64'(run_len[i]) << sh);
					rsp.last       = (i == runs - 1);
					map_responses.push_back(rsp);
				end
			end
		end else if (f == FUNC_CLEAR) begin
			rsp.changed = (page_cnt != 0);
			commit_bits = '0;
			page_cnt    = 0;
			map_responses.push_back(rsp);
		end else begin
			// commit or decommit of a page range
			first = 64'(off) >> sh;
			stop  = first + (64'(size) >> sh);
			if (((64'(off) & mask) != 0) || ((64'(size) & mask) != 0)) begin
				rsp.error = 1'b1;
			end else if (size != 0) begin
				if (stop > 64'(PAGES)) begin
					rsp.error = 1'b1;
				end else begin
					want = (f == FUNC_COMMIT);
					for (i = int'(first); i < int'(stop); i++) begin
						if (commit_bits[i] != want) begin
							commit_bits[i] = want;
							page_cnt       = want ? page_cnt + 1 : page_cnt - 1;
							rsp.changed    = 1'b1;
						end
					end
				end
			end
			rsp.committed_bytes = count_bytes(page_cnt, sh);
			map_responses.push_back(rsp);
		end
	endtask

	// send one request item, predicting its results on acceptance
	task automatic issue_request(input logic [FUNC_W-1:0] f,
			input logic [ADDR_W-1:0] off, input logic [ADDR_W-1:0] size);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     = 1'b1;
		func         = f;
		offset_bytes = off;
		size_bytes   = size;
		do @(posedge clk); while (!in_ready);
		update_commit_map(f, off, size);
	endtask

	// stop sending and wait until every predicted item has come back
	task automatic wait_until_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (map_responses.size() != 0)
			@(posedge clk);
		repeat (PAGES + 8) @(posedge clk);
	endtask

	// register write while the block is idle
	task automatic set_page_shift(input logic [SHIFT_W-1:0] value);
		wait_until_idle();
		@(negedge clk);
		cfg_we   = 1'b1;
		cfg_data = value;
		@(negedge clk);
		cfg_we     = 1'b0;
		page_shift = value;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// result side: random stalls, compare each item with the oldest prediction
	initial begin : collect_responses
		int            stall;
		map_response_t want;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 3);
			@(negedge clk);
			if (stall != 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			if (map_responses.size() == 0) begin
				$error("result item with no prediction waiting");
				fail_count++;
			end else begin
				want = map_responses.pop_front();
				check_field("changed", 32'(want.changed), 32'(changed));
				check_field("error", 32'(want.error), 32'(error));
				check_field("committed_bytes", 32'(want.committed_bytes),
					32'(committed_bytes));
				check_field("run_valid", 32'(want.run_valid), 32'(run_valid));
				check_field("run_offset", 32'(want.run_offset), 32'(run_offset));
				check_field("run_size", 32'(want.run_size), 32'(run_size));
				check_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	// run limit
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// extremes at the reset page size of 64 KiB
	task automatic test_directed_edges();
		issue_request(FUNC_SCAN, 32'h0, 32'h0);
		issue_request(FUNC_DECOMMIT, 32'h0, 32'h1_0000);
		issue_request(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_request(FUNC_COMMIT, 32'h0, 32'h40_0000);
		issue_request(FUNC_COMMIT, 32'h3F_0000, 32'h1_0000);
		issue_request(FUNC_SCAN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_request(FUNC_DECOMMIT, 32'h10_0000, 32'h2_0000);
		issue_request(FUNC_SCAN, 32'h1234_5678, 32'h0);
		// misaligned offset, then misaligned size
		issue_request(FUNC_COMMIT, 32'h8000, 32'h1_0000);
		issue_request(FUNC_DECOMMIT, 32'h1_0000, 32'h1_8000);
		// empty range far beyond the map
		issue_request(FUNC_COMMIT, 32'hFFFF_0000, 32'h0);
		issue_request(FUNC_DECOMMIT, 32'hFFFF_0000, 32'h0);
		// ranges running past the last page, then a misaligned all-ones range
		issue_request(FUNC_COMMIT, 32'h3F_0000, 32'h2_0000);
		issue_request(FUNC_COMMIT, 32'hFFFF_0000, 32'hFFFF_0000);
		issue_request(FUNC_DECOMMIT, 32'h0, 32'h41_0000);
		issue_request(FUNC_COMMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_request(FUNC_CLEAR, 32'h0, 32'h0);
		issue_request(FUNC_SCAN, 32'h0, 32'h0);
	endtask

	// alternating pages give the largest number of runs a scan can report
	task automatic test_max_runs();
		int p;
		set_page_shift(5'd0);
		no_idle = 1'b1;
		issue_request(FUNC_COMMIT, 32'h0, 32'(PAGES));
		for (p = 1; p < PAGES; p += 2)
			issue_request(FUNC_DECOMMIT, 32'(p), 32'h1);
		no_idle = 1'b0;
		issue_request(FUNC_SCAN, 32'h0, 32'h0);
		issue_request(FUNC_CLEAR, 32'h0, 32'h0);
	endtask

	// a few requests at each of several page sizes, saturating shifts included
	task automatic test_page_shifts();
		logic [SHIFT_W-1:0] shifts[6];
		int                 k;
		int                 sh;
		shifts = '{5'd31, 5'd1, 5'd7, 5'd16, 5'd17, 5'd12};
		for (k = 0; k < 6; k++) begin
			set_page_shift(shifts[k]);
			sh = page_bits();
			issue_request(FUNC_COMMIT, ADDR_W'(64'd3 << sh), ADDR_W'(64'd5 << sh));
			issue_request(FUNC_SCAN, 32'h0, 32'h0);
			issue_request(FUNC_DECOMMIT, ADDR_W'(64'd63 << sh), ADDR_W'(64'd1 << sh));
			issue_request(FUNC_COMMIT, ADDR_W'((64'd1 << sh) >> 1), ADDR_W'(64'd1 << sh));
		end
	endtask

	// random requests: mostly well-formed ranges, some noise and broken ranges
	task automatic test_random_requests();
		int                 phase;
		int                 n;
		int                 pick;
		int                 shape;
		int                 sh;
		int                 start;
		int                 len;
		logic [FUNC_W-1:0]  f;
		logic [ADDR_W-1:0]  off;
		logic [ADDR_W-1:0]  size;
		logic [SHIFT_W-1:0] phase_shift;
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: phase_shift = SHIFT_W'($urandom_range(0, 15));
				1: phase_shift = 5'd16;
				2: phase_shift = SHIFT_W'($urandom_range(17, 31));
				3: phase_shift = 5'd0;
				default: phase_shift = SHIFT_W'($urandom_range(1, 31));
			endcase
			set_page_shift(phase_shift);
			no_idle = (phase == 2);
			sh = page_bits();
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// the sender holds off once until all results are back
				if (phase == 1 && n == PHASE_ITEMS / 2)
					wait_until_idle();
				pick = $urandom_range(0, 99);
				if (pick < 40)
					f = FUNC_COMMIT;
				else if (pick < 70)
					f = FUNC_DECOMMIT;
				else if (pick < 96)
					f = FUNC_SCAN;
				else
					f = FUNC_CLEAR;
				start = $urandom_range(0, PAGES - 1);
				if ($urandom_range(0, 7) == 0)
					len = $urandom_range(1, PAGES - start);
				else
					len = $urandom_range(1, (PAGES - start < 8) ? PAGES - start : 8);
				off   = ADDR_W'(64'(start) << sh);
				size  = ADDR_W'(64'(len) << sh);
				shape = $urandom_range(0, 99);
				if (f == FUNC_SCAN || f == FUNC_CLEAR || (shape >= 80 && shape < 88)) begin
					// ignored fields and raw noise carry any bit pattern
					off  = $urandom;
					size = $urandom;
				end else if (shape < 80) begin
					// well-formed range, kept as drawn
				end else if (shape < 92 && sh != 0) begin
					// misaligned offset or size
					if ($urandom_range(0, 1) == 0)
						off = off + ADDR_W'($urandom_range(1, (1 << sh) - 1));
					else
						size = size + ADDR_W'($urandom_range(1, (1 << sh) - 1));
				end else if (shape < 96) begin
					// range running past the last page
					size = ADDR_W'(64'(PAGES - start + $urandom_range(1, 4)) << sh);
				end else begin
					// empty range at any aligned offset
					off  = ADDR_W'((64'($urandom) >> sh) << sh);
					size = '0;
				end
				issue_request(f, off, size);
			end
		end
		no_idle = 1'b0;
	endtask

	// reset, tests in turn, drain and verdict
	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		func         = FUNC_COMMIT;
		offset_bytes = '0;
		size_bytes   = '0;
		out_ready    = 1'b0;
		commit_bits  = '0;
		page_cnt     = 0;
		page_shift   = 5'd16;
		fail_count   = 0;
		no_idle      = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_edges();
		test_max_runs();
		test_page_shifts();
		test_random_requests();

		wait_until_idle();
		if (map_responses.size() != 0) begin
			$error("%0d predicted result items never arrived", map_responses.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
